// ----- rtl/core/uemr_pkg.sv -----
// ----------------------------------------------------------------------------
// uemr_pkg: shared types and constants of the echo median ranger
// Field widths, command and status codes, register indexes, reset values
// and the payload struct passed from the scaling stage to the filter stage.
// ----------------------------------------------------------------------------
package uemr_pkg;

    localparam int CMD_W      = 2;
    localparam int PULSE_W    = 16;
    localparam int TICK_W     = 32;
    localparam int DIST_W     = 24;
    localparam int SCALE_W    = 16;
    localparam int FRAC_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int SEQ_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Outcome of one ranging attempt
    typedef enum logic [CMD_W-1:0] {
        CMD_START_FAIL   = 2'd0,
        CMD_ECHO_OK      = 2'd1,
        CMD_ECHO_TIMEOUT = 2'd2,
        CMD_OTHER_ERR    = 2'd3
    } cmd_t;

    // Reported status
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_NOECHO  = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID = 2'd2;

    // Register reset values
    localparam logic [SCALE_W-1:0] SCALE_RESET     = 16'd43904;
    localparam logic [DIST_W-1:0]  MIN_VALID_RESET = 24'd30000;
    localparam logic [DIST_W-1:0]  MAX_VALID_RESET = 24'd4000000;

    // Measurement after scaling, as held in the first stage
    typedef struct packed {
        cmd_t                cmd;
        logic [PULSE_W-1:0]  echo_len_us;
        logic [TICK_W-1:0]   now_ms;
        logic [DIST_W-1:0]   raw_um;
    } meas_t;

endpackage

// ----- rtl/core/uemr_if.sv -----
// ----------------------------------------------------------------------------
// uemr_if: channel interfaces of the echo median ranger
// Measurement input, result output and configuration write channels, each
// with valid, ready and payload, and a source and a sink modport.
// ----------------------------------------------------------------------------
interface uemr_meas_if import uemr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [PULSE_W-1:0] echo_len_us;
    logic [TICK_W-1:0]  now_ms;

    modport source (output valid, cmd, echo_len_us, now_ms, input ready);
    modport sink   (input valid, cmd, echo_len_us, now_ms, output ready);
endinterface

interface uemr_result_if import uemr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   distance_um;
    logic [PULSE_W-1:0]  echo_width_us;
    logic [TICK_W-1:0]   stamp_ms;
    logic [SEQ_W-1:0]    sequence_res;

    modport source (output valid, status, distance_um, echo_width_us,
                    stamp_ms, sequence_res, input ready);
    modport sink   (input valid, status, distance_um, echo_width_us,
                    stamp_ms, sequence_res, output ready);
endinterface

interface uemr_cfg_if import uemr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/ultrasonic_echo_median_ranger.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_median_ranger: echo ranging with a median history filter
// Scales each echo width to micrometres, classifies it against the valid
// window and, for an echo in it, reports the median of recent valid distances.
//
//   channel   role    beat contents
//   meas      sink    cmd, echo_len_us, now_ms
//   result    source  status, distance_um, echo_width_us, stamp_ms,
//                     sequence_res
//   cfg       sink    index, data (always ready)
//
// One measurement is accepted per cycle while the result side does not stall;
// its result is registered (scaling register, then filter and result register).
// The filter stage reads and updates the history in the same cycle, so
// each item sees the state left by the one before it.
// A stalled result holds; the stall reaches meas.ready once both stages fill.
// Reset sets all but the status and width registers to their defaults at once.
// ----------------------------------------------------------------------------
module ultrasonic_echo_median_ranger import uemr_pkg::*;
#(
    parameter int HISTORY_DEPTH = 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    uemr_cfg_if.sink      cfg,
    uemr_meas_if.sink     meas,
    uemr_result_if.source result
);

    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    // Configuration registers
    logic [SCALE_W-1:0] scale_reg;
    logic [DIST_W-1:0]  min_reg;
    logic [DIST_W-1:0]  max_reg;

    // Filter state
    logic [HISTORY_DEPTH-1:0][DIST_W-1:0] hist_reg;
    logic [HISTORY_DEPTH-1:0][DIST_W-1:0] hist_next;
    logic [HISTORY_DEPTH-1:0][DIST_W-1:0] push_hist;
    logic [SLOT_W-1:0]                    slot_reg;
    logic [SLOT_W-1:0]                    slot_next;
    logic [SLOT_W-1:0]                    push_slot;
    logic [CNT_W-1:0]                     count_reg;
    logic [CNT_W-1:0]                     count_next;
    logic [CNT_W-1:0]                     push_count;
    logic [DIST_W-1:0]                    last_dist_reg;
    logic [DIST_W-1:0]                    last_dist_next;
    logic [TICK_W-1:0]                    last_time_reg;
    logic [TICK_W-1:0]                    last_time_next;
    logic [SEQ_W-1:0]                     seq_reg;
    logic [SEQ_W-1:0]                     seq_next;

    // Result register
    logic                out_valid_reg;
    status_t             status_reg;
    status_t             status_next;
    logic [PULSE_W-1:0]  width_reg;
    logic [PULSE_W-1:0]  width_next;

    // Stage handshake
    logic  a_valid;
    logic  a_ready;
    meas_t a_item;
    logic  fire;
    logic [DIST_W-1:0] median_um;

    // Write configuration; out-of-list indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            min_reg   <= MIN_VALID_RESET;
            max_reg   <= MAX_VALID_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SCALE:     scale_reg <= cfg.data[SCALE_W-1:0];
                REG_MIN_VALID: min_reg   <= cfg.data;
                REG_MAX_VALID: max_reg   <= cfg.data;
                default:       ;
            endcase
        end
    end

    // Scaling stage
    uemr_scale u_scale
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .meas     (meas),
        .scale_q8 (scale_reg),
        .a_valid  (a_valid),
        .a_ready  (a_ready),
        .a_item   (a_item)
    );

    assign a_ready = !out_valid_reg || result.ready;
    assign fire    = a_valid && a_ready;

    // Build the history as it would be after pushing this distance
    always_comb
    begin
        push_hist           = hist_reg;
        push_hist[slot_reg] = a_item.raw_um;
        push_slot = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);
        push_count = (count_reg == CNT_W'(HISTORY_DEPTH)) ? count_reg
                                                          : count_reg + CNT_W'(1);
    end

    uemr_median #(
        .DEPTH  (HISTORY_DEPTH),
        .CNT_W  (CNT_W),
        .SLOT_W (SLOT_W)
    ) u_median
    (
        .hist      (push_hist),
        .count     (push_count),
        .median_um (median_um)
    );

    // Classify the measurement and pick the next state
    always_comb
    begin
        hist_next      = hist_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        last_dist_next = last_dist_reg;
        last_time_next = last_time_reg;
        width_next     = '0;
        status_next    = ST_TIMEOUT;
        seq_next       = seq_reg + SEQ_W'(1);
        case (a_item.cmd)
            CMD_ECHO_OK:
            begin
                width_next = a_item.echo_len_us;
                if (a_item.raw_um < min_reg)
                begin
                    last_dist_next = a_item.raw_um;
                    status_next    = ST_RANGE;
                end
                else if (a_item.raw_um > max_reg)
                begin
                    last_dist_next = max_reg;
                    last_time_next = a_item.now_ms;
                    status_next    = ST_NOECHO;
                end
                else
                begin
                    hist_next      = push_hist;
                    slot_next      = push_slot;
                    count_next     = push_count;
                    last_dist_next = median_um;
                    last_time_next = a_item.now_ms;
                    status_next    = ST_OK;
                end
            end
            CMD_ECHO_TIMEOUT:
            begin
                last_dist_next = max_reg;
                last_time_next = a_item.now_ms;
                status_next    = ST_NOECHO;
            end
            default:
            begin
                status_next = ST_TIMEOUT;
            end
        endcase
    end

    // Advance filter state on each processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= '0;
            slot_reg      <= '0;
            count_reg     <= '0;
            last_dist_reg <= '0;
            last_time_reg <= '0;
            seq_reg       <= '0;
        end
        else if (fire)
        begin
            hist_reg      <= hist_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            last_dist_reg <= last_dist_next;
            last_time_reg <= last_time_next;
            seq_reg       <= seq_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            out_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            width_reg  <= width_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = status_reg;
    assign result.distance_um   = last_dist_reg;
    assign result.echo_width_us = width_reg;
    assign result.stamp_ms      = last_time_reg;
    assign result.sequence_res  = seq_reg;

endmodule

// ----- rtl/core/uemr_scale.sv -----
// ----------------------------------------------------------------------------
// uemr_scale: input register and pulse scaling
// Accepts one measurement beat, scales the echo width by the Q8.8 factor
// and holds the distance with the rest of the measurement for the filter.
// ----------------------------------------------------------------------------
module uemr_scale import uemr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    uemr_meas_if.sink          meas,
    input  logic [SCALE_W-1:0] scale_q8,
    output logic               a_valid,
    input  logic               a_ready,
    output meas_t              a_item
);

    localparam int PROD_W = PULSE_W + SCALE_W;

    logic              valid_reg;
    meas_t             item_reg;
    meas_t             item_next;
    logic [PROD_W-1:0] prod;
    logic              accept;

    // Take a new beat when empty or when the held one moves on
    assign meas.ready = !valid_reg || a_ready;
    assign accept     = meas.valid && meas.ready;

    // Scale to micrometres; the 16x16 product shifted by 8 always fits 24 bits
    always_comb
    begin
        prod                  = PROD_W'(meas.echo_len_us) * PROD_W'(scale_q8);
        item_next.cmd         = cmd_t'(meas.cmd);
        item_next.echo_len_us = meas.echo_len_us;
        item_next.now_ms      = meas.now_ms;
        item_next.raw_um      = prod[FRAC_W +: DIST_W];
    end

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (meas.ready)
        begin
            valid_reg <= meas.valid;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign a_valid = valid_reg;
    assign a_item  = item_reg;

endmodule

// ----- rtl/core/uemr_median.sv -----
// ----------------------------------------------------------------------------
// uemr_median: median of the held history entries
// Ranks each held entry against the others (ties broken by slot), picks the
// middle rank for an odd count and the floored mean of the two middle ranks
// for an even count.
// ----------------------------------------------------------------------------
module uemr_median import uemr_pkg::*;
#(
    parameter int DEPTH  = 3,
    parameter int CNT_W  = 2,
    parameter int SLOT_W = 2
)
(
    input  logic [DEPTH-1:0][DIST_W-1:0] hist,
    input  logic [CNT_W-1:0]             count,
    output logic [DIST_W-1:0]            median_um
);

    logic [SLOT_W-1:0] rank [DEPTH];
    logic [CNT_W-1:0]  mid;
    logic [DIST_W-1:0] hi_val;
    logic [DIST_W-1:0] lo_val;
    logic [DIST_W:0]   pair_sum;

    // Rank every held entry: number of held entries sorted before it
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            rank[j] = '0;
            for (int k = 0; k < DEPTH; k++)
            begin
                if ((CNT_W'(k) < count) &&
                    ((hist[k] < hist[j]) || ((hist[k] == hist[j]) && (k < j))))
                begin
                    rank[j] = rank[j] + SLOT_W'(1);
                end
            end
        end
    end

    // Select the middle entries and form the median
    always_comb
    begin
        mid    = count >> 1;
        hi_val = '0;
        lo_val = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            if (CNT_W'(j) < count)
            begin
                if (CNT_W'(rank[j]) == mid)
                begin
                    hi_val = hist[j];
                end
                if (CNT_W'(rank[j]) == mid - CNT_W'(1))
                begin
                    lo_val = hist[j];
                end
            end
        end
        pair_sum = {1'b0, lo_val} + {1'b0, hi_val};
        if (count == '0)
        begin
            median_um = '0;
        end
        else if (count[0])
        begin
            median_um = hi_val;
        end
        else
        begin
            median_um = pair_sum[DIST_W:1];
        end
    end

endmodule

// ----- rtl/core/uemr_checker.sv -----
// ----------------------------------------------------------------------------
// uemr_checker: port-level checks of the echo median ranger
// Watches the measurement and result channels and checks result ordering,
// held fields on timeout and the number of beats in flight.
// ----------------------------------------------------------------------------
module uemr_checker import uemr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                meas_valid,
    input logic                meas_ready,
    input logic                res_valid,
    input logic                res_ready,
    input logic [STATUS_W-1:0] res_status,
    input logic [DIST_W-1:0]   res_distance,
    input logic [PULSE_W-1:0]  res_width,
    input logic [TICK_W-1:0]   res_time,
    input logic [SEQ_W-1:0]    res_seq
);

    logic              meas_beat;
    logic              res_beat;
    logic [1:0]        inflight_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [TICK_W-1:0] time_reg;

    assign meas_beat = meas_valid && meas_ready;
    assign res_beat  = res_valid && res_ready;

    // Track beats in flight and the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            seq_reg      <= '0;
            dist_reg     <= '0;
            time_reg     <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 2'(meas_beat) - 2'(res_beat);
            if (res_beat)
            begin
                seq_reg  <= res_seq;
                dist_reg <= res_distance;
                time_reg <= res_time;
            end
        end
    end

    // A waiting result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // A result is only shown for an accepted measurement
    a_res_owned: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> inflight_reg != 2'd0)
        else $error("result without accepted measurement");

    // Sequence numbers of delivered results step by one
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_beat |-> res_seq == seq_reg + SEQ_W'(1))
        else $error("sequence gap or repeat");

    // A timeout keeps the last distance and sample time
    a_timeout_keep: assert property (@(posedge clk) disable iff (!rst_n)
        res_beat && (res_status == ST_TIMEOUT) |->
            (res_distance == dist_reg) && (res_time == time_reg) && (res_width == '0))
        else $error("timeout changed held fields");

endmodule

bind ultrasonic_echo_median_ranger uemr_checker u_uemr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .meas_valid   (meas.valid),
    .meas_ready   (meas.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_status   (result.status),
    .res_distance (result.distance_um),
    .res_width    (result.echo_width_us),
    .res_time     (result.stamp_ms),
    .res_seq      (result.sequence_res)
);

// ----- verif/tb_ultrasonic_echo_median_ranger.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_median_ranger: self-checking bench for the echo ranger
// Offers outcome beats in bursts with gaps and stalls the result side. Every
// result beat is checked against an untimed model of the scaling, the range
// classification and the median history filter. The run covers several
// register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_median_ranger import uemr_pkg::*; ();

    localparam int HIST_DEPTH    = 3;
    localparam int IDLE_LIMIT    = 4000;
    localparam int LONG_HOLD     = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTED  = 10;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum int {
        RX_ALWAYS,
        RX_LIGHT,
        RX_PERIODIC,
        RX_HEAVY
    } rx_mode_t;

    typedef struct packed {
        status_t             status;
        logic [DIST_W-1:0]   distance_um;
        logic [PULSE_W-1:0]  echo_width_us;
        logic [TICK_W-1:0]   stamp_ms;
        logic [SEQ_W-1:0]    sequence_res;
    } report_t;

    // Predicts result beats of the ranger and checks the ones observed
    class ranger_scoreboard;
        report_t             pending_reports[$];
        logic [SCALE_W-1:0]  scale_q8;
        logic [DIST_W-1:0]   min_um;
        logic [DIST_W-1:0]   max_um;
        logic [DIST_W-1:0]   ring [HIST_DEPTH];
        int unsigned         ring_slot;
        int unsigned         ring_fill;
        logic [DIST_W-1:0]   held_dist;
        logic [TICK_W-1:0]   held_tick;
        logic [SEQ_W-1:0]    beat_count;
        int unsigned         mismatches;

        function new();
            scale_q8   = SCALE_RESET;
            min_um     = MIN_VALID_RESET;
            max_um     = MAX_VALID_RESET;
            foreach (ring[i])
                ring[i] = '0;
            ring_slot  = 0;
            ring_fill  = 0;
            held_dist  = '0;
            held_tick  = '0;
            beat_count = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SCALE:     scale_q8 = data[SCALE_W-1:0];
                REG_MIN_VALID: min_um   = data[DIST_W-1:0];
                REG_MAX_VALID: max_um   = data[DIST_W-1:0];
                default:       ;
            endcase
        endfunction

        // Median of the held entries; floored mean of the middle pair when even
        function logic [DIST_W-1:0] ring_median();
            logic [DIST_W-1:0] sorted [HIST_DEPTH];
            logic [DIST_W-1:0] v;
            logic [DIST_W:0]   pair_sum;
            int                k;
            for (int i = 0; i < ring_fill; i++)
                sorted[i] = ring[i];
            for (int i = 1; i < ring_fill; i++)
            begin
                v = sorted[i];
                k = i;
                while (k > 0 && sorted[k-1] > v)
                begin
                    sorted[k] = sorted[k-1];
                    k--;
                end
                sorted[k] = v;
            end
            if (ring_fill % 2 == 1)
                return sorted[ring_fill/2];
            pair_sum = sorted[ring_fill/2 - 1] + sorted[ring_fill/2];
            return pair_sum[DIST_W:1];
        endfunction

        function void note_measurement(cmd_t cmd, logic [PULSE_W-1:0] pulse,
                                       logic [TICK_W-1:0] now);
            report_t            want;
            logic [31:0]        product;
            logic [DIST_W-1:0]  raw;
            beat_count++;
            want.echo_width_us = '0;
            case (cmd)
                CMD_ECHO_OK:
                begin
                    // 16x16 product shifted by 8 always fits 24 bits: no saturation
                    product = pulse * scale_q8;
                    raw = product[FRAC_W +: DIST_W];
                    want.echo_width_us = pulse;
                    if (raw < min_um)
                    begin
                        held_dist   = raw;
                        want.status = ST_RANGE;
                    end
                    else if (raw > max_um)
                    begin
                        held_dist   = max_um;
                        held_tick   = now;
                        want.status = ST_NOECHO;
                    end
                    else
                    begin
                        ring[ring_slot] = raw;
                        ring_slot = (ring_slot + 1) % HIST_DEPTH;
                        if (ring_fill < HIST_DEPTH)
                            ring_fill++;
                        held_dist   = ring_median();
                        held_tick   = now;
                        want.status = ST_OK;
                    end
                end
                CMD_ECHO_TIMEOUT:
                begin
                    held_dist   = max_um;
                    held_tick   = now;
                    want.status = ST_NOECHO;
                end
                default:
                    want.status = ST_TIMEOUT;
            endcase
            want.distance_um  = held_dist;
            want.stamp_ms     = held_tick;
            want.sequence_res = beat_count;
            pending_reports.push_back(want);
        endfunction

        function void check_report(report_t got);
            report_t want;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("unexpected result beat: st %0d dist %0d width %0d t %0d seq %0d",
                             got.status, got.distance_um, got.echo_width_us,
                             got.stamp_ms, got.sequence_res);
                return;
            end
            want = pending_reports.pop_front();
            if (got.status !== want.status || got.distance_um !== want.distance_um ||
                got.echo_width_us !== want.echo_width_us ||
                got.stamp_ms !== want.stamp_ms ||
                got.sequence_res !== want.sequence_res)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                begin
                    $display("mismatch seq %0d: expected st %0d dist %0d width %0d t %0d seq %0d",
                             want.sequence_res, want.status, want.distance_um,
                             want.echo_width_us, want.stamp_ms, want.sequence_res);
                    $display("                 actual   st %0d dist %0d width %0d t %0d seq %0d",
                             got.status, got.distance_um, got.echo_width_us,
                             got.stamp_ms, got.sequence_res);
                end
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    ranger_scoreboard  sb = new();
    rx_mode_t          rx_mode = RX_ALWAYS;
    int                hold_token = 0;
    int                hold_seen = 0;
    int                hold_left = 0;
    int                rx_phase = 0;
    int                idle_cycles = 0;
    logic [TICK_W-1:0] tick = '0;

    uemr_cfg_if    cfg_ch ();
    uemr_meas_if   meas_ch ();
    uemr_result_if res_ch ();

    ultrasonic_echo_median_ranger #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .meas   (meas_ch),
        .result (res_ch)
    );

    // 50 MHz clock
    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    // Drive result ready: long hold on request, otherwise the current pattern
    always @(negedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
        end
        rx_phase = (rx_phase + 1) % 5;
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:   res_ch.ready <= 1'b1;
                RX_LIGHT:    res_ch.ready <= ($urandom_range(9) >= 3);
                RX_PERIODIC: res_ch.ready <= (rx_phase >= 2);
                default:     res_ch.ready <= ($urandom_range(9) >= 7);
            endcase
        end
    end

    // Check every result beat taken
    always @(posedge clk)
    begin : take_result
        report_t got;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got.status        = status_t'(res_ch.status);
            got.distance_um   = res_ch.distance_um;
            got.echo_width_us = res_ch.echo_width_us;
            got.stamp_ms      = res_ch.stamp_ms;
            got.sequence_res  = res_ch.sequence_res;
            sb.check_report(got);
        end
    end

    // Abort when no beat moves on any channel for too long
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((meas_ch.valid === 1'b1 && meas_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Offer one measurement beat and hold it until taken
    task automatic send_measurement(cmd_t cmd, logic [PULSE_W-1:0] pulse,
                                    logic [TICK_W-1:0] now);
        @(negedge clk);
        meas_ch.valid       <= 1'b1;
        meas_ch.cmd         <= cmd;
        meas_ch.echo_len_us <= pulse;
        meas_ch.now_ms      <= now;
        do
            @(posedge clk);
        while (meas_ch.ready !== 1'b1);
        sb.note_measurement(cmd, pulse, now);
    endtask

    task automatic pause_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            meas_ch.valid <= 1'b0;
        end
    endtask

    // Stop offering and wait until every expected result has come
    task automatic wait_drained();
        pause_sender(1);
        while (sb.pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_settings(logic [SCALE_W-1:0] scale, logic [DIST_W-1:0] min_um,
                                  logic [DIST_W-1:0] max_um);
        wait_drained();
        write_register(REG_SCALE, CFG_DATA_W'(scale));
        write_register(REG_MIN_VALID, min_um);
        write_register(REG_MAX_VALID, max_um);
    endtask

    // Pick a pulse width: full range, corners, or aimed at the valid window
    function automatic logic [PULSE_W-1:0] pick_pulse();
        longint lo;
        longint hi;
        longint target;
        longint p;
        case ($urandom_range(7))
            0, 1: return PULSE_W'($urandom_range(16'hFFFF));
            2:    return PULSE_W'($urandom_range(15));
            3:    return PULSE_W'(16'hFFFF - $urandom_range(15));
            default: ;
        endcase
        if (sb.scale_q8 == 0)
            return PULSE_W'($urandom);
        lo = longint'(sb.min_um);
        hi = longint'(sb.max_um);
        if (lo > hi)
        begin
            target = lo;
            lo = hi;
            hi = target;
        end
        if ($urandom_range(1) == 1)
            target = lo + ($urandom % (hi - lo + 1));
        else
            target = ($urandom_range(1) == 1 ? lo : hi) + longint'($urandom_range(8)) - 4;
        p = target * 256 / longint'(sb.scale_q8) + longint'($urandom_range(2)) - 1;
        if (p < 0)
            p = 0;
        if (p > 65535)
            p = 65535;
        return p[PULSE_W-1:0];
    endfunction

    task automatic send_random_measurement();
        cmd_t        cmd;
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 6)
            cmd = CMD_ECHO_OK;
        else if (pick == 6)
            cmd = CMD_START_FAIL;
        else if (pick == 7)
            cmd = CMD_ECHO_TIMEOUT;
        else
            cmd = CMD_OTHER_ERR;
        // Mostly a rising tick, now and then a jump anywhere
        if ($urandom_range(15) == 0)
            tick = $urandom;
        else
            tick = tick + $urandom_range(120);
        send_measurement(cmd, pick_pulse(), tick);
    endtask

    // Send beats in bursts of random length, with random gaps if asked
    task automatic send_bursts(int n_items, bit with_gaps);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < n_items; i++)
            begin
                send_random_measurement();
                sent++;
            end
            if (with_gaps)
                pause_sender($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        meas_ch.valid       = 1'b0;
        meas_ch.cmd         = '0;
        meas_ch.echo_len_us = '0;
        meas_ch.now_ms      = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        res_ch.ready        = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: every outcome, field extremes, filter fill and wrap
        rx_mode = RX_LIGHT;
        send_measurement(CMD_START_FAIL, 16'hFFFF, 32'd0);
        send_measurement(CMD_ECHO_OK, 16'd0, 32'd10);
        send_measurement(CMD_ECHO_OK, 16'hFFFF, 32'hFFFF_FFFF);
        send_measurement(CMD_OTHER_ERR, 16'h5A5A, 32'd20);
        send_measurement(CMD_ECHO_TIMEOUT, 16'hA5A5, 32'd30);
        pause_sender(2);
        send_measurement(CMD_ECHO_OK, 16'd1000, 32'd40);
        send_measurement(CMD_ECHO_OK, 16'd3001, 32'd50);
        send_measurement(CMD_ECHO_OK, 16'd2000, 32'd60);
        send_measurement(CMD_ECHO_OK, 16'd500, 32'd70);
        send_measurement(CMD_ECHO_OK, 16'd175, 32'd80);
        send_measurement(CMD_ECHO_OK, 16'd174, 32'd90);
        send_measurement(CMD_START_FAIL, 16'd0, 32'd100);
        send_measurement(CMD_ECHO_OK, 16'd23324, 32'd110);
        send_measurement(CMD_ECHO_OK, 16'd23323, 32'd120);

        // Unit scale through masked data, narrow window, spare index ignored
        wait_drained();
        write_register(REG_SPARE, CFG_DATA_W'($urandom));
        write_register(REG_SCALE, 24'hAB0100);
        write_register(REG_MIN_VALID, 24'd100);
        write_register(REG_MAX_VALID, 24'd200);
        send_measurement(CMD_ECHO_OK, 16'd99, 32'hFFFF_FFFF);
        send_measurement(CMD_ECHO_OK, 16'd100, 32'd0);
        send_measurement(CMD_ECHO_OK, 16'd200, 32'hFFFF_FFFF);
        send_measurement(CMD_ECHO_OK, 16'd201, 32'd1);
        send_measurement(CMD_ECHO_OK, 16'd150, 32'd2);
        send_bursts(60, 1'b1);

        apply_settings(SCALE_RESET, MIN_VALID_RESET, MAX_VALID_RESET);
        send_bursts(100, 1'b1);

        // Widest window, largest scale, no idling on either side
        apply_settings(16'hFFFF, 24'd0, 24'hFF_FFFF);
        rx_mode = RX_ALWAYS;
        send_bursts(90, 1'b0);

        // Zero scale: every echo lands at zero distance
        apply_settings(16'd0, 24'd0, 24'd100);
        rx_mode = RX_PERIODIC;
        send_bursts(40, 1'b1);
        apply_settings(16'd0, 24'd1, 24'd100);
        send_bursts(30, 1'b1);

        // Minimum above maximum; long result hold while beats keep coming
        apply_settings(SCALE_RESET, 24'd500000, 24'd100000);
        rx_mode = RX_LIGHT;
        hold_token++;
        send_bursts(90, 1'b0);

        apply_settings(16'd1, 24'hFF_FFFF, 24'd0);
        rx_mode = RX_HEAVY;
        send_bursts(70, 1'b1);

        // Zero-width window; drain fully halfway through
        apply_settings(16'd300, 24'd0, 24'd0);
        rx_mode = RX_PERIODIC;
        send_bursts(35, 1'b1);
        wait_drained();
        send_bursts(35, 1'b1);

        apply_settings(16'd12345, 24'd1000, 24'd2000000);
        rx_mode = RX_LIGHT;
        send_bursts(90, 1'b1);

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
